// File: sv/hld_pkg.sv
`default_nettype none

package hld_pkg;

	localparam int FAN_W     = 9;
	localparam int COST_W    = 16;
	localparam int UNIT_W    = 16;
	localparam int LVL_N     = 4;
	localparam int DIV_N     = LVL_N - 1;
	localparam int REM_W     = FAN_W * DIV_N;
	localparam int TOT_W     = FAN_W * LVL_N;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = COST_W;

	localparam int MAX_LEVELS_DEF = 4;
	localparam int ID_BITS_DEF    = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAN0  = 3'd0,
		CFG_FAN1  = 3'd1,
		CFG_FAN2  = 3'd2,
		CFG_FAN3  = 3'd3,
		CFG_COST0 = 3'd4,
		CFG_COST1 = 3'd5,
		CFG_COST2 = 3'd6,
		CFG_COST3 = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_a;
		logic [UNIT_W-1:0] unit_b;
	} req_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              bad_id;
	} res_t;

endpackage

`default_nettype wire

// File: sv/hierarchy_level_distance.sv
`default_nettype none

// Hierarchy level distance between two processing units.
//
// A request (unit_a, unit_b) is taken at a rising edge where start is high
// and busy is low. busy is always low: a new request may be issued every
// cycle. Each request produces exactly one result, shown on result for one
// cycle with done high. The receiver cannot hold results off, and none is
// needed: results leave in request order at the rate requests came in.
//
// The user must write the fan-out and cost registers through cfg_we /
// cfg_index / cfg_data only while no request is in flight; the block itself
// does not enforce this. The prefix products of the fan-outs are kept in a
// short registered multiplier chain; the first three pipeline stages only
// carry the ids while that chain settles. The next ID_BITS stages run a
// restoring division, one id bit per stage, of both ids by each prefix
// product. The highest level whose quotients differ is the highest
// differing digit. A final stage compares the ids against the product of
// all fan-outs and picks the level cost. Reset sets all fan-outs to one and
// all costs to zero, and empties the pipeline.
module hierarchy_level_distance import hld_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF,
	parameter int ID_BITS    = ID_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire req_t                 req,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      done,
	output res_t                      result
);

	localparam int NST = ID_BITS + 3;
	localparam int LST = NST - 1;

	logic [FAN_W-1:0]  fan_q [LVL_N];
	logic [COST_W-1:0] cost_q [LVL_N];
	logic [FAN_W-1:0]  fan_eff [LVL_N];

	logic [REM_W-1:0]  p_q [DIV_N];
	logic [TOT_W-1:0]  tot_q;
	logic [2*FAN_W-1:0] m1;
	logic [REM_W-1:0]  m2;
	logic [TOT_W-1:0]  m3;

	logic              v_s [NST];
	logic [ID_BITS-1:0] a_s [NST];
	logic [ID_BITS-1:0] b_s [NST];
	logic [REM_W-1:0]  ra_s [NST][DIV_N];
	logic [REM_W-1:0]  rb_s [NST][DIV_N];
	logic [DIV_N-1:0]  ne_s [NST];

	logic              done_q;
	res_t              result_q;
	res_t              res_d;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LVL_N; k++) begin
				fan_q[k]  <= FAN_W'(1);
				cost_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FAN0:  fan_q[0]  <= cfg_data[FAN_W-1:0];
				CFG_FAN1:  fan_q[1]  <= cfg_data[FAN_W-1:0];
				CFG_FAN2:  fan_q[2]  <= cfg_data[FAN_W-1:0];
				CFG_FAN3:  fan_q[3]  <= cfg_data[FAN_W-1:0];
				CFG_COST0: cost_q[0] <= cfg_data[COST_W-1:0];
				CFG_COST1: cost_q[1] <= cfg_data[COST_W-1:0];
				CFG_COST2: cost_q[2] <= cfg_data[COST_W-1:0];
				CFG_COST3: cost_q[3] <= cfg_data[COST_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero fan-out and any level beyond MAX_LEVELS act as fan-out one.
	for (genvar k = 0; k < LVL_N; k++) begin : g_fan
		assign fan_eff[k] = (k < MAX_LEVELS && fan_q[k] != '0) ? fan_q[k] : FAN_W'(1);
	end

	assign m1 = fan_eff[0] * fan_eff[1];
	assign m2 = p_q[1][2*FAN_W-1:0] * fan_eff[2];
	assign m3 = p_q[2] * fan_eff[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q[0] <= REM_W'(1);
			p_q[1] <= REM_W'(1);
			p_q[2] <= REM_W'(1);
			tot_q  <= TOT_W'(1);
		end else begin
			p_q[0] <= REM_W'(fan_eff[0]);
			p_q[1] <= REM_W'(m1);
			p_q[2] <= m2;
			tot_q  <= m3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		a_s[0]  <= ID_BITS'(req.unit_a);
		b_s[0]  <= ID_BITS'(req.unit_b);
		ne_s[0] <= '0;
		for (int d = 0; d < DIV_N; d++) begin
			ra_s[0][d] <= '0;
			rb_s[0][d] <= '0;
		end
	end

	for (genvar s = 1; s < NST; s++) begin : g_st
		logic [REM_W:0]   sa [DIV_N];
		logic [REM_W:0]   sb [DIV_N];
		logic [REM_W-1:0] na [DIV_N];
		logic [REM_W-1:0] nb [DIV_N];
		logic [DIV_N-1:0] ga;
		logic [DIV_N-1:0] gb;

		if (s < 3) begin : g_wait
			always_comb begin
				ga = '0;
				gb = '0;
				for (int d = 0; d < DIV_N; d++) begin
					sa[d] = '0;
					sb[d] = '0;
					na[d] = ra_s[s-1][d];
					nb[d] = rb_s[s-1][d];
				end
			end
		end else begin : g_div
			// One restoring division step on both ids for every prefix product.
			always_comb begin
				for (int d = 0; d < DIV_N; d++) begin
					sa[d] = {ra_s[s-1][d], a_s[s-1][ID_BITS-1-(s-3)]};
					sb[d] = {rb_s[s-1][d], b_s[s-1][ID_BITS-1-(s-3)]};
					ga[d] = sa[d] >= {1'b0, p_q[d]};
					gb[d] = sb[d] >= {1'b0, p_q[d]};
					na[d] = ga[d] ? REM_W'(sa[d] - {1'b0, p_q[d]}) : sa[d][REM_W-1:0];
					nb[d] = gb[d] ? REM_W'(sb[d] - {1'b0, p_q[d]}) : sb[d][REM_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s] <= 1'b0;
			end else begin
				v_s[s] <= v_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			a_s[s]  <= a_s[s-1];
			b_s[s]  <= b_s[s-1];
			ne_s[s] <= ne_s[s-1] | (ga ^ gb);
			for (int d = 0; d < DIV_N; d++) begin
				ra_s[s][d] <= na[d];
				rb_s[s][d] <= nb[d];
			end
		end
	end

	// Quotient by the product of levels below k differs exactly when some
	// digit at level k or above differs, so the highest such k wins.
	always_comb begin
		res_d.bad_id = (TOT_W'(a_s[LST]) >= tot_q) || (TOT_W'(b_s[LST]) >= tot_q);
		priority if (res_d.bad_id) begin
			res_d.cost = '0;
		end else if (ne_s[LST][2]) begin
			res_d.cost = cost_q[3];
		end else if (ne_s[LST][1]) begin
			res_d.cost = cost_q[2];
		end else if (ne_s[LST][0]) begin
			res_d.cost = cost_q[1];
		end else if (a_s[LST] != b_s[LST]) begin
			res_d.cost = cost_q[0];
		end else begin
			res_d.cost = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[LST];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

endmodule

`default_nettype wire

// File: tb/sv/hierarchy_level_distance_tb.sv
`default_nettype none

module hierarchy_level_distance_tb;
	import hld_pkg::*;

	// Margin that drain() waits out before any register write.
	localparam int LATENCY     = ID_BITS_DEF + 3;
	localparam int RANDOM_REQS = 1250;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	res_t                 result;

	hierarchy_level_distance DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Local copy of the fan-out and cost registers, as the block should hold them.
	logic [FAN_W-1:0]  fanout_shadow [LVL_N];
	logic [COST_W-1:0] cost_shadow [LVL_N];

	// Distances still owed by the block, oldest first.
	res_t pending_dist [$];
	int   error_count;
	int   cycle_count;

	// Splits both ids into mixed-radix digits and returns the cost of the highest
	// level where the digits differ, or flags bad_id for an id outside the tree.
	function automatic res_t level_distance(input req_t r);
		res_t             d;
		longint unsigned  radix [LVL_N];
		longint unsigned  total;
		longint unsigned  a;
		longint unsigned  b;
		int               top;
		total = 1;
		a = r.unit_a;
		b = r.unit_b;
		top = -1;
		for (int k = 0; k < LVL_N; k++) begin
			radix[k] = (fanout_shadow[k] == 0 || k >= MAX_LEVELS_DEF) ? 1 : fanout_shadow[k];
			total = total * radix[k];
		end
		d.cost = '0;
		d.bad_id = 1'b0;
		if (a >= total || b >= total) begin
			d.bad_id = 1'b1;
			return d;
		end
		for (int k = 0; k < LVL_N; k++) begin
			if ((a % radix[k]) != (b % radix[k]))
				top = k;
			a = a / radix[k];
			b = b / radix[k];
		end
		if (top >= 0)
			d.cost = cost_shadow[top];
		return d;
	endfunction

	// Results cannot be held off, so every cycle with done high is a result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_dist.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual cost=%0d bad_id=%0b",
					$time, result.cost, result.bad_id);
				error_count++;
			end else begin
				want = pending_dist.pop_front();
				if (result.cost !== want.cost) begin
					$display("%0t: cost mismatch, expected %0d, actual %0d",
						$time, want.cost, result.cost);
					error_count++;
				end
				if (result.bad_id !== want.bad_id) begin
					$display("%0t: bad_id mismatch, expected %0b, actual %0b",
						$time, want.bad_id, result.bad_id);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Writes one register; only called while nothing is in flight.
	// The caller drops the write enable after its last write.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= CFG_FAN3)
			fanout_shadow[idx] = val[FAN_W-1:0];
		else
			cost_shadow[idx - CFG_COST0] = val;
	endtask

	task automatic set_tree(input int f0, f1, f2, f3, input int c0, c1, c2, c3);
		write_reg(CFG_FAN0, CFG_W'(f0));
		write_reg(CFG_FAN1, CFG_W'(f1));
		write_reg(CFG_FAN2, CFG_W'(f2));
		write_reg(CFG_FAN3, CFG_W'(f3));
		write_reg(CFG_COST0, CFG_W'(c0));
		write_reg(CFG_COST1, CFG_W'(c1));
		write_reg(CFG_COST2, CFG_W'(c2));
		write_reg(CFG_COST3, CFG_W'(c3));
		cfg_we <= 1'b0;
	endtask

	// Sender gap: usually none or short, now and then long.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Issues one request and queues its expected distance at acceptance.
	// start stays high between back-to-back requests.
	task automatic issue_req(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_dist = {pending_dist, level_distance(r)};
	endtask

	// Drains the pipeline, then waits out the latency before any register write.
	task automatic drain();
		start <= 1'b0;
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Random id: mostly inside the tree, sometimes anywhere in 16 bits.
	function automatic logic [UNIT_W-1:0] pick_id(input int unsigned total);
		if (total == 0 || $urandom_range(0, 9) == 0 || total > 65536)
			return $urandom_range(0, 65535);
		return $urandom_range(0, total - 1);
	endfunction

	// Directed requests under the tree 4 x 8 x 16 x 32 and costs 10..13.
	// A row with a typed-in expectation is checked against it as well.
	typedef struct {
		logic [UNIT_W-1:0] a;
		logic [UNIT_W-1:0] b;
		logic              typed;
		res_t              want;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{16'd0,     16'd0,     1'b1, '{16'd0,  1'b0}},
		'{16'd0,     16'd1,     1'b1, '{16'd10, 1'b0}},
		'{16'd0,     16'd4,     1'b1, '{16'd11, 1'b0}},
		'{16'd0,     16'd32,    1'b1, '{16'd12, 1'b0}},
		'{16'd0,     16'd512,   1'b1, '{16'd13, 1'b0}},
		'{16'd16383, 16'd0,     1'b1, '{16'd13, 1'b0}},
		'{16'd16383, 16'd16383, 1'b1, '{16'd0,  1'b0}},
		'{16'd16384, 16'd0,     1'b1, '{16'd0,  1'b1}},
		'{16'd0,     16'd16384, 1'b1, '{16'd0,  1'b1}},
		'{16'hFFFF,  16'hFFFF,  1'b1, '{16'd0,  1'b1}},
		'{16'd5,     16'd6,     1'b0, '{16'd0,  1'b0}},
		'{16'd300,   16'd301,   1'b0, '{16'd0,  1'b0}},
		'{16'd1234,  16'd9876,  1'b0, '{16'd0,  1'b0}},
		'{16'hAAAA,  16'h5555,  1'b0, '{16'd0,  1'b0}}
	};

	initial begin
		req_t        r;
		res_t        got;
		int unsigned total;
		int          fan [LVL_N];
		error_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FAN0;
		cfg_data = '0;
		for (int k = 0; k < LVL_N; k++) begin
			fanout_shadow[k] = 1;
			cost_shadow[k] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every fan-out is one: only id 0 is inside the tree.
		issue_req('{unit_a: 16'd0, unit_b: 16'd0});
		issue_req('{unit_a: 16'd1, unit_b: 16'd0});
		drain();

		set_tree(4, 8, 16, 32, 10, 11, 12, 13);
		foreach (dir_rows[i]) begin
			r.unit_a = dir_rows[i].a;
			r.unit_b = dir_rows[i].b;
			got = level_distance(r);
			if (dir_rows[i].typed && got != dir_rows[i].want) begin
				$display("%0t: directed row %0d, expected cost=%0d bad_id=%0b, actual cost=%0d bad_id=%0b",
					$time, i, dir_rows[i].want.cost, dir_rows[i].want.bad_id,
					got.cost, got.bad_id);
				error_count++;
			end
			issue_req(r);
		end
		drain();

		// A zero fan-out acts as one; fan-outs above 256 are used as written.
		set_tree(0, 511, 0, 128, 16'hFFFF, 16'h8001, 16'h1234, 16'hFFFF);
		issue_req('{unit_a: 16'd510, unit_b: 16'd511});
		issue_req('{unit_a: 16'd511, unit_b: 16'd0});
		issue_req('{unit_a: 16'hFFFF, unit_b: 16'd1});
		issue_req('{unit_a: 16'd65405, unit_b: 16'd65404});
		drain();

		// Random phases, each with a fresh tree; extremes come up now and then.
		for (int phase = 0; phase < 25; phase++) begin
			for (int k = 0; k < LVL_N; k++) begin
				case ($urandom_range(0, 5))
					0: fan[k] = 1;
					1: fan[k] = 256;
					2: fan[k] = $urandom_range(0, 511);
					default: fan[k] = $urandom_range(1, 16);
				endcase
			end
			set_tree(fan[0], fan[1], fan[2], fan[3],
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			total = 1;
			for (int k = 0; k < LVL_N; k++)
				total = total * ((fanout_shadow[k] == 0) ? 1 : fanout_shadow[k]);
			for (int n = 0; n < RANDOM_REQS / 25; n++) begin
				r.unit_a = pick_id(total);
				// Often the partner shares the upper digits so low levels get hit.
				if ($urandom_range(0, 2) == 0)
					r.unit_b = r.unit_a ^ (16'(1) << $urandom_range(0, 3));
				else
					r.unit_b = pick_id(total);
				issue_req(r);
				idle_gap();
			end
			drain();
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
